### hw/rtl/fk_phase_shift_extrapolator_macros.svh
`ifndef FK_PHASE_SHIFT_EXTRAPOLATOR_MACROS_SVH
`define FK_PHASE_SHIFT_EXTRAPOLATOR_MACROS_SVH

// Same-cycle check, clocked on clock and disabled during reset.
`define FK_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle check, clocked on clock and disabled during reset.
`define FK_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/fk_pse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fk_pse_pkg;

   localparam int FREQ_BINS    = 8192;
   localparam int WAVE_BINS    = 1024;
   localparam int SAMPLE_BITS  = 24;
   localparam int FREQ_W       = $clog2(FREQ_BINS);
   localparam int WAVE_W       = $clog2(WAVE_BINS);
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int SQ_STAGES    = 32;
   localparam int CORDIC_ITERS = 24;
   localparam int GUARD_BITS   = 6;
   localparam int XW           = SAMPLE_BITS + 10;
   localparam int ZW           = 34;
   localparam int GAIN_SHIFT   = 24 + GUARD_BITS;
   localparam int PROD_W       = XW + 24;

   localparam logic [33:0] TURN_PER_RAD = 34'd10937044409;
   localparam logic [23:0] GAIN_Q24     = 24'd10188014;

   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KX        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOWNESS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_SQ    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TWO_DEPTH = 3'd6;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
   } sample_type;

   typedef struct packed {
      logic       vld;
      logic       pass;
      logic [63:0] v;
      logic [63:0] res;
      sample_type smp;
   } sq_type;

   typedef struct packed {
      logic                 vld;
      logic                 pass;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cr_type;

   // Arctangent of 2^-i as a fraction of one turn, 2^32 per turn.
   function automatic logic [31:0] atan_turn(input int i);
      case (i)
         0: return 32'h20000000;   1: return 32'h12E4051E;
         2: return 32'h09FB385B;   3: return 32'h051111D4;
         4: return 32'h028B0D43;   5: return 32'h0145D7E1;
         6: return 32'h00A2F61E;   7: return 32'h00517C55;
         8: return 32'h0028BE53;   9: return 32'h00145F2F;
         10: return 32'h000A2F98;  11: return 32'h000517CC;
         12: return 32'h00028BE6;  13: return 32'h000145F3;
         14: return 32'h0000A2FA;  15: return 32'h0000517D;
         16: return 32'h000028BE;  17: return 32'h0000145F;
         18: return 32'h00000A30;  19: return 32'h00000518;
         20: return 32'h0000028C;  21: return 32'h00000146;
         22: return 32'h000000A3;  23: return 32'h00000051;
         default: return 32'h0;
      endcase
   endfunction

endpackage

`default_nettype wire

### hw/rtl/fk_pse_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fk_pse_req_if;
   import fk_pse_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [FREQ_W-1:0]             freq_bin;
   logic signed [WAVE_W-1:0]      wave_bin;
   logic signed [SAMPLE_BITS-1:0] data_re;
   logic signed [SAMPLE_BITS-1:0] data_im;

   modport source (output valid, freq_bin, wave_bin, data_re, data_im, input ready);
   modport sink (input valid, freq_bin, wave_bin, data_re, data_im, output ready);
endinterface

`default_nettype wire

### hw/rtl/fk_pse_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fk_pse_rsp_if;
   import fk_pse_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_re;
   logic signed [SAMPLE_BITS-1:0] out_im;
   logic                          passed;

   modport source (output valid, out_re, out_im, passed, input ready);
   modport sink (input valid, out_re, out_im, passed, output ready);
endinterface

`default_nettype wire

### hw/rtl/fk_phase_shift_extrapolator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir   Beat contents
// req_ch    in    freq_bin, wave_bin, data_re, data_im
// rsp_ch    out   out_re, out_im, passed
// csr_*     in    csr_we, csr_index, csr_wdata (write only)
//
// One bin per cycle unless a result beat waits at rsp_ch; the pipe holds product and
// cone-test stages, 32 square-root stages (one root bit each), phase stages, the
// quarter-turn pre-rotation stage, 24 CORDIC stages and gain and saturation stages.
// Synchronous active-high reset clears valid bits and loads register defaults.
// When a result beat waits at rsp_ch, the whole pipeline holds and req_ch.ready
// drops; nothing is lost or repeated.

`include "fk_phase_shift_extrapolator_macros.svh"

module fk_phase_shift_extrapolator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [fk_pse_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fk_pse_pkg::CSR_DATA_W-1:0] csr_wdata,
   fk_pse_req_if.sink                             req_ch,
   fk_pse_rsp_if.source                           rsp_ch
);
   import fk_pse_pkg::*;

   localparam logic [FREQ_W-1:0] HALF_FREQ = FREQ_W'(FREQ_BINS / 2);

   logic [FREQ_W-1:0] band_low_ff, band_high_ff;
   logic [31:0]       omega_step_ff, kx_step_ff, slowness_ff;
   logic [15:0]       cos_sq_ff;
   logic [23:0]       two_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_low_ff   <= '0;
         band_high_ff  <= FREQ_W'(4096);
         omega_step_ff <= '0;
         kx_step_ff    <= '0;
         slowness_ff   <= '0;
         cos_sq_ff     <= '0;
         two_depth_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BAND_LOW:  band_low_ff   <= csr_wdata[FREQ_W-1:0];
            CSR_BAND_HIGH: band_high_ff  <= csr_wdata[FREQ_W-1:0];
            CSR_OMEGA:     omega_step_ff <= csr_wdata;
            CSR_KX:        kx_step_ff    <= csr_wdata;
            CSR_SLOWNESS:  slowness_ff   <= csr_wdata;
            CSR_COS_SQ:    cos_sq_ff     <= csr_wdata[15:0];
            CSR_TWO_DEPTH: two_depth_ff  <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_vld_ff;
   assign adv          = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Stage 1: band test, omega and |kx| products.
   logic [WAVE_W-1:0]      wabs;
   logic                   band_in;
   logic [FREQ_W+31:0]     omega_in, omega_ff;
   logic [WAVE_W+31:0]     akx_in, akx_ff;
   logic                   vld1_ff, pass1_ff;
   sample_type             smp1_ff;

   always_comb begin
      wabs     = req_ch.wave_bin[WAVE_W-1] ? WAVE_W'(-req_ch.wave_bin)
                                           : WAVE_W'(req_ch.wave_bin);
      band_in  = !(req_ch.freq_bin < band_low_ff) && !(req_ch.freq_bin > band_high_ff)
                 && !(req_ch.freq_bin > HALF_FREQ);
      omega_in = (FREQ_W+32)'(req_ch.freq_bin) * (FREQ_W+32)'(omega_step_ff);
      akx_in   = (WAVE_W+32)'(wabs) * (WAVE_W+32)'(kx_step_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) vld1_ff <= 1'b0;
      else if (adv) begin
         vld1_ff    <= req_ch.valid;
         pass1_ff   <= band_in;
         omega_ff   <= omega_in;
         akx_ff     <= akx_in;
         smp1_ff.re <= req_ch.data_re;
         smp1_ff.im <= req_ch.data_im;
      end
   end

   // Stage 2: omega times slowness as two partial products.
   logic [FREQ_W+31:0] mhi_in, mhi_ff;
   logic [63:0]        mlo_in, mlo_ff;
   logic [31:0]        kx_in, kx2_ff, kx3_ff;
   logic               vld2_ff, pass2_ff;
   sample_type         smp2_ff;

   always_comb begin
      mhi_in = (FREQ_W+32)'(omega_ff[FREQ_W+31:32]) * (FREQ_W+32)'(slowness_ff);
      mlo_in = 64'(omega_ff[31:0]) * 64'(slowness_ff);
      kx_in  = 32'(akx_ff >> 12);
   end

   always_ff @(posedge clock) begin
      if (reset) vld2_ff <= 1'b0;
      else if (adv) begin
         vld2_ff  <= vld1_ff;
         pass2_ff <= pass1_ff;
         mhi_ff   <= mhi_in;
         mlo_ff   <= mlo_in;
         kx2_ff   <= kx_in;
         smp2_ff  <= smp1_ff;
      end
   end

   // Stage 3: sum the partial products, saturate p to 32 bits.
   logic [49:0] psum;
   logic [31:0] p_in, p_ff;
   logic        vld3_ff, pass3_ff;
   sample_type  smp3_ff;

   always_comb begin
      psum = (50'(mhi_ff) << 4) + 50'(mlo_ff >> 28);
      p_in = (|psum[49:32]) ? 32'hFFFF_FFFF : psum[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) vld3_ff <= 1'b0;
      else if (adv) begin
         vld3_ff  <= vld2_ff;
         pass3_ff <= pass2_ff;
         p_ff     <= p_in;
         kx3_ff   <= kx2_ff;
         smp3_ff  <= smp2_ff;
      end
   end

   // Stage 4: squares.
   logic [63:0] p2_ff, k2_ff;
   logic        vld4_ff, pass4_ff;
   sample_type  smp4_ff;

   always_ff @(posedge clock) begin
      if (reset) vld4_ff <= 1'b0;
      else if (adv) begin
         vld4_ff  <= vld3_ff;
         pass4_ff <= pass3_ff;
         p2_ff    <= 64'(p_ff) * 64'(p_ff);
         k2_ff    <= 64'(kx3_ff) * 64'(kx3_ff);
         smp4_ff  <= smp3_ff;
      end
   end

   // Stage 5: difference and the two halves of the cone threshold.
   logic [63:0] d_ff, thr_hi_ff;
   logic [15:0] thr_lo_ff;
   logic        vld5_ff, pass5_ff;
   sample_type  smp5_ff;

   always_ff @(posedge clock) begin
      if (reset) vld5_ff <= 1'b0;
      else if (adv) begin
         vld5_ff   <= vld4_ff;
         pass5_ff  <= pass4_ff && (p2_ff >= k2_ff);
         d_ff      <= p2_ff - k2_ff;
         thr_hi_ff <= 64'(p2_ff[63:16]) * 64'(cos_sq_ff);
         thr_lo_ff <= 16'((32'(p2_ff[15:0]) * 32'(cos_sq_ff)) >> 16);
         smp5_ff   <= smp4_ff;
      end
   end

   // Stage 6 feeds the square-root pipe after the cone compare.
   sq_type sq_ff [SQ_STAGES+1];
   sq_type sq_in [SQ_STAGES];

   always_ff @(posedge clock) begin
      if (reset) sq_ff[0].vld <= 1'b0;
      else if (adv) begin
         sq_ff[0].vld  <= vld5_ff;
         sq_ff[0].pass <= pass5_ff
                          && ({1'b0, d_ff} > (65'(thr_hi_ff) + 65'(thr_lo_ff)));
         sq_ff[0].v    <= d_ff;
         sq_ff[0].res  <= '0;
         sq_ff[0].smp  <= smp5_ff;
      end
   end

   // One root bit per stage; the trial bit walks down two places each stage.
   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
      localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] trial;
      always_comb begin
         sq_in[k] = sq_ff[k];
         trial    = sq_ff[k].res + SQ_BIT;
         if (sq_ff[k].v >= trial) begin
            sq_in[k].v   = sq_ff[k].v - trial;
            sq_in[k].res = (sq_ff[k].res >> 1) + SQ_BIT;
         end else begin
            sq_in[k].res = sq_ff[k].res >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) sq_ff[k+1].vld <= 1'b0;
         else if (adv) sq_ff[k+1] <= sq_in[k];
      end
   end

   // Phase: two_depth * kz, then radians to binary angle in two partial products.
   logic [55:0] phase_ff;
   logic [61:0] pa_ff, pb_ff;
   logic [31:0] angle_ff;
   logic [63:0] asum;
   logic        vph1_ff, vph2_ff, vph3_ff, pph1_ff, pph2_ff, pph3_ff;
   sample_type  sph1_ff, sph2_ff, sph3_ff;

   assign asum = 64'(pa_ff) + (64'(pb_ff) << 28);

   always_ff @(posedge clock) begin
      if (reset) begin
         vph1_ff <= 1'b0;
         vph2_ff <= 1'b0;
         vph3_ff <= 1'b0;
      end else if (adv) begin
         vph1_ff  <= sq_ff[SQ_STAGES].vld;
         pph1_ff  <= sq_ff[SQ_STAGES].pass;
         sph1_ff  <= sq_ff[SQ_STAGES].smp;
         phase_ff <= 56'(two_depth_ff) * 56'(sq_ff[SQ_STAGES].res[31:0]);
         vph2_ff  <= vph1_ff;
         pph2_ff  <= pph1_ff;
         sph2_ff  <= sph1_ff;
         pa_ff    <= 62'(phase_ff[27:0]) * 62'(TURN_PER_RAD);
         pb_ff    <= 62'(phase_ff[55:28]) * 62'(TURN_PER_RAD);
         vph3_ff  <= vph2_ff;
         pph3_ff  <= pph2_ff;
         sph3_ff  <= sph2_ff;
         angle_ff <= asum[63:32];
      end
   end

   // A half turn minus the phase folds in the negation; a quarter-turn
   // pre-rotation brings the residual angle into CORDIC range.
   cr_type               cr_ff [CORDIC_ITERS+1];
   cr_type               cr_in [CORDIC_ITERS];
   cr_type               cr0_in;
   logic [31:0]          rot, rq, zu;
   logic [1:0]           quad;
   logic signed [XW-1:0] xg, yg;

   always_comb begin
      rot  = 32'h8000_0000 - angle_ff;
      rq   = rot + 32'h2000_0000;
      quad = rq[31:30];
      zu   = rot - {quad, 30'b0};
      xg   = {{(XW-SAMPLE_BITS-GUARD_BITS){sph3_ff.re[SAMPLE_BITS-1]}},
              sph3_ff.re, {GUARD_BITS{1'b0}}};
      yg   = {{(XW-SAMPLE_BITS-GUARD_BITS){sph3_ff.im[SAMPLE_BITS-1]}},
              sph3_ff.im, {GUARD_BITS{1'b0}}};
      cr0_in.vld  = vph3_ff;
      cr0_in.pass = pph3_ff;
      cr0_in.z    = {{(ZW-32){zu[31]}}, zu};
      case (quad)
         2'd1: begin
            cr0_in.x = -yg;
            cr0_in.y = xg;
         end
         2'd2: begin
            cr0_in.x = -xg;
            cr0_in.y = -yg;
         end
         2'd3: begin
            cr0_in.x = yg;
            cr0_in.y = -xg;
         end
         default: begin
            cr0_in.x = xg;
            cr0_in.y = yg;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) cr_ff[0].vld <= 1'b0;
      else if (adv) cr_ff[0] <= cr0_in;
   end

   for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_cordic
      localparam logic signed [ZW-1:0] ATAN = $signed({{(ZW-32){1'b0}}, atan_turn(k)});
      logic signed [XW-1:0] dx, dy;
      always_comb begin
         dx       = cr_ff[k].y >>> k;
         dy       = cr_ff[k].x >>> k;
         cr_in[k] = cr_ff[k];
         if (!cr_ff[k].z[ZW-1]) begin
            cr_in[k].x = cr_ff[k].x - dx;
            cr_in[k].y = cr_ff[k].y + dy;
            cr_in[k].z = cr_ff[k].z - ATAN;
         end else begin
            cr_in[k].x = cr_ff[k].x + dx;
            cr_in[k].y = cr_ff[k].y - dy;
            cr_in[k].z = cr_ff[k].z + ATAN;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) cr_ff[k+1].vld <= 1'b0;
         else if (adv) cr_ff[k+1] <= cr_in[k];
      end
   end

   // Gain correction on magnitudes, then round half away from zero and saturate.
   cr_type                cr_last;
   logic [XW-1:0]         ax, ay;
   logic [PROD_W-1:0]     gx_ff, gy_ff, rx, ry;
   logic                  nx_ff, ny_ff, vg_ff, pg_ff;

   always_comb begin
      cr_last = cr_ff[CORDIC_ITERS];
      ax      = cr_last.x[XW-1] ? XW'(-cr_last.x) : XW'(cr_last.x);
      ay      = cr_last.y[XW-1] ? XW'(-cr_last.y) : XW'(cr_last.y);
      rx      = (gx_ff + (PROD_W'(1) << (GAIN_SHIFT - 1))) >> GAIN_SHIFT;
      ry      = (gy_ff + (PROD_W'(1) << (GAIN_SHIFT - 1))) >> GAIN_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) vg_ff <= 1'b0;
      else if (adv) begin
         vg_ff <= cr_last.vld;
         pg_ff <= cr_last.pass;
         nx_ff <= cr_last.x[XW-1];
         ny_ff <= cr_last.y[XW-1];
         gx_ff <= PROD_W'(ax) * PROD_W'(GAIN_Q24);
         gy_ff <= PROD_W'(ay) * PROD_W'(GAIN_Q24);
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] sat_mag(input logic neg,
                                                             input logic [PROD_W-1:0] mag);
      localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << (SAMPLE_BITS - 1);
      logic signed [SAMPLE_BITS-1:0] res;
      if (!neg) res = (mag >= LIM) ? SAMPLE_BITS'(LIM - 1) : SAMPLE_BITS'(mag);
      else      res = (mag >= LIM) ? SAMPLE_BITS'(LIM) : SAMPLE_BITS'(-mag);
      return res;
   endfunction

   logic signed [SAMPLE_BITS-1:0] rsp_re_ff, rsp_im_ff;
   logic                          rsp_pass_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else if (adv) begin
         rsp_vld_ff  <= vg_ff;
         rsp_pass_ff <= pg_ff;
         rsp_re_ff   <= pg_ff ? sat_mag(nx_ff, rx) : '0;
         rsp_im_ff   <= pg_ff ? sat_mag(ny_ff, ry) : '0;
      end
   end

   assign rsp_ch.valid  = rsp_vld_ff;
   assign rsp_ch.out_re = rsp_re_ff;
   assign rsp_ch.out_im = rsp_im_ff;
   assign rsp_ch.passed = rsp_pass_ff;

   `FK_ASSERT_SAME(a_zeroed_bin, rsp_ch.valid && !rsp_ch.passed, rsp_ch.out_re == '0 && rsp_ch.out_im == '0, "zeroed bin carries a nonzero sample")
   `FK_ASSERT_NEXT(a_stall_holds, !adv, $stable(sq_ff[SQ_STAGES/2].vld) && $stable(cr_ff[CORDIC_ITERS/2].vld), "pipeline moved during a stall")
   `FK_ASSERT_NEXT(a_accept_enters, req_ch.valid && req_ch.ready, vld1_ff, "accepted beat did not enter the pipeline")

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import fk_pse_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int PIPE_DEPTH = 70;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic                          passed;
   } bin_result_type;

   localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic no_idle = 1'b0;
   int mismatches = 0;
   int stall_cycles = 0;

   fk_pse_req_if req_ch ();
   fk_pse_rsp_if rsp_ch ();

   fk_phase_shift_extrapolator u_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   // Shadow copy of the configuration registers.
   logic [63:0] band_lo, band_hi, omega_step, kx_step, slowness, cos_sq, two_depth;
   bin_result_type expected_bins[$];

   initial begin
      req_ch.valid = 1'b0;
      req_ch.freq_bin = '0;
      req_ch.wave_bin = '0;
      req_ch.data_re = '0;
      req_ch.data_im = '0;
      rsp_ch.ready = 1'b0;
   end

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (!reset)
         rsp_ch.ready = no_idle ? 1'b1 : ($urandom_range(99) >= 30);
   end

   function automatic logic signed [SAMPLE_BITS-1:0] scale_sat(input longint v);
      logic [63:0] m, r;
      longint s;
      m = (v < 0) ? -v : v;
      r = (m * 64'd10188014 + (64'd1 << 29)) >> 30;
      s = (v < 0) ? -longint'(r) : longint'(r);
      if (s > 8388607) s = 8388607;
      if (s < -8388608) s = -8388608;
      return s[SAMPLE_BITS-1:0];
   endfunction

   function automatic bin_result_type extrapolate_bin(input logic [FREQ_W-1:0] f,
         input logic signed [WAVE_W-1:0] w, input logic signed [SAMPLE_BITS-1:0] re,
         input logic signed [SAMPLE_BITS-1:0] im);
      bin_result_type res;
      logic [63:0] omega, p, kx, p2, k2, d, thr, kz, acc, bitv, phase, prod, wabs;
      logic [31:0] angle, rot, qsum, zu;
      logic [1:0] q;
      longint wl, x, y, z, t, dx, dy;
      res.re = '0;
      res.im = '0;
      res.passed = 1'b0;
      if (f < band_lo || f > band_hi || f > FREQ_BINS / 2) return res;
      omega = 64'(f) * omega_step;
      p = (((omega >> 32) * slowness) << 4) + (((omega & 64'hFFFFFFFF) * slowness) >> 28);
      if (p > 64'hFFFFFFFF) p = 64'hFFFFFFFF;
      wl = w;
      wabs = (wl < 0) ? -wl : wl;
      kx = (wabs * kx_step) >> 12;
      if (kx > 64'hFFFFFFFF) kx = 64'hFFFFFFFF;
      p2 = p * p;
      k2 = kx * kx;
      if (p2 < k2) return res;
      d = p2 - k2;
      thr = (p2 >> 16) * cos_sq + (((p2 & 64'hFFFF) * cos_sq) >> 16);
      if (!(d > thr)) return res;
      // Integer square root, one result bit per pass.
      acc = d;
      kz = 0;
      bitv = 64'd1 << 62;
      while (bitv > acc) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (acc >= kz + bitv) begin
            acc = acc - (kz + bitv);
            kz = (kz >> 1) + bitv;
         end else begin
            kz = kz >> 1;
         end
         bitv = bitv >> 2;
      end
      phase = two_depth * kz;
      prod = phase * 64'd10937044409;
      angle = prod[63:32];
      // A half turn minus the phase folds the negation into the rotation.
      rot = 32'h80000000 - angle;
      qsum = rot + 32'h20000000;
      q = qsum[31:30];
      zu = rot - {q, 30'b0};
      z = longint'(signed'(zu));
      x = longint'(re) * 64;
      y = longint'(im) * 64;
      if (q == 2'd1) begin
         t = x; x = -y; y = t;
      end else if (q == 2'd2) begin
         x = -x; y = -y;
      end else if (q == 2'd3) begin
         t = x; x = y; y = -t;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(ATAN_TURNS[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(ATAN_TURNS[i]);
         end
      end
      res.re = scale_sat(x);
      res.im = scale_sat(y);
      res.passed = 1'b1;
      return res;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      bin_result_type exp_bin;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bins.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: re=%0d im=%0d passed=%0b",
                  rsp_ch.out_re, rsp_ch.out_im, rsp_ch.passed);
         end else begin
            exp_bin = expected_bins.pop_front();
            if (rsp_ch.out_re !== exp_bin.re || rsp_ch.out_im !== exp_bin.im ||
                  rsp_ch.passed !== exp_bin.passed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp re=%0d im=%0d passed=%0b, got re=%0d im=%0d p=%0b",
                     exp_bin.re, exp_bin.im, exp_bin.passed,
                     rsp_ch.out_re, rsp_ch.out_im, rsp_ch.passed);
            end
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_BAND_LOW:  band_lo = val & 32'h1FFF;
         CSR_BAND_HIGH: band_hi = val & 32'h1FFF;
         CSR_OMEGA:     omega_step = val;
         CSR_KX:        kx_step = val;
         CSR_SLOWNESS:  slowness = val;
         CSR_COS_SQ:    cos_sq = val & 32'hFFFF;
         CSR_TWO_DEPTH: two_depth = val & 32'hFFFFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_setup(input logic [31:0] lo, hi, om, kxs, sl, cs, td);
      write_reg(CSR_BAND_LOW, lo);
      write_reg(CSR_BAND_HIGH, hi);
      write_reg(CSR_OMEGA, om);
      write_reg(CSR_KX, kxs);
      write_reg(CSR_SLOWNESS, sl);
      write_reg(CSR_COS_SQ, cs);
      write_reg(CSR_TWO_DEPTH, td);
   endtask

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_bin(input logic [FREQ_W-1:0] f, input logic signed [WAVE_W-1:0] w,
         input logic signed [SAMPLE_BITS-1:0] re, input logic signed [SAMPLE_BITS-1:0] im);
      while (!no_idle && $urandom_range(99) < 30) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.freq_bin = f;
      req_ch.wave_bin = w;
      req_ch.data_re = re;
      req_ch.data_im = im;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_bins.push_back(extrapolate_bin(f, w, re, im));
      @(negedge clock);
   endtask

   task automatic drain;
      req_ch.valid = 1'b0;
      while (expected_bins.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH) @(negedge clock);
   endtask

   task automatic send_random_bin;
      logic [FREQ_W-1:0] f;
      logic signed [SAMPLE_BITS-1:0] re, im;
      f = ($urandom_range(9) == 0) ? FREQ_W'($urandom) : FREQ_W'($urandom_range(4096));
      re = SAMPLE_BITS'($urandom);
      im = SAMPLE_BITS'($urandom);
      if ($urandom_range(15) == 0) re = $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
      if ($urandom_range(15) == 0) im = $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
      send_bin(f, WAVE_W'($urandom), re, im);
   endtask

   task automatic test_reset_defaults;
      send_bin(13'd0, 10'sd0, 24'sd1000, -24'sd1000);
      send_bin(13'd4096, 10'sd5, 24'h7FFFFF, 24'h800000);
      drain();
   endtask

   task automatic test_band_and_cone;
      load_setup(32'd10, 32'd4000, 32'h00010000, 32'd25165824, 32'd2863311, 32'h4000,
         32'h001234);
      send_bin(13'd0, 10'sd0, 24'sd4096, 24'sd0);
      send_bin(13'd9, 10'sd0, 24'sd4096, 24'sd0);
      send_bin(13'd10, 10'sd0, 24'sd4096, 24'sd100);
      send_bin(13'd4000, 10'sd3, 24'sd123456, -24'sd654321);
      send_bin(13'd4001, 10'sd3, 24'sd123456, -24'sd654321);
      send_bin(13'd2000, -10'sd512, 24'sd5000, 24'sd5000);
      send_bin(13'd2000, 10'sd511, 24'sd5000, 24'sd5000);
      send_bin(13'd3000, 10'sd100, 24'h7FFFFF, 24'h7FFFFF);
      send_bin(13'd3000, -10'sd100, 24'h800000, 24'h800000);
      drain();
   endtask

   task automatic test_extremes;
      // Saturated wavenumbers and frequencies; bins above 4096 still fail the band.
      load_setup(32'd0, 32'h1FFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFF,
         32'hFFFFFF);
      send_bin(13'd4096, 10'sd0, 24'h7FFFFF, 24'h800000);
      send_bin(13'd4097, 10'sd0, 24'sd1, 24'sd1);
      send_bin(13'h1FFF, -10'sd1, 24'sd1, 24'sd1);
      send_bin(13'd1, -10'sd512, 24'h800000, 24'h7FFFFF);
      drain();
      load_setup(32'd0, 32'h1FFF, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'd0, 32'hFFFFFF);
      send_bin(13'd4096, 10'sd511, 24'h800000, 24'h800000);
      send_bin(13'd1, 10'sd0, 24'h7FFFFF, 24'h7FFFFF);
      drain();
   endtask

   task automatic test_empty_band;
      load_setup(32'd4096, 32'd0, 32'h00010000, 32'd0, 32'd2863311, 32'd0, 32'd256);
      send_bin(13'd0, 10'sd0, 24'sd77, 24'sd77);
      send_bin(13'd2048, 10'sd0, 24'sd77, 24'sd77);
      send_bin(13'd4096, 10'sd0, 24'sd77, 24'sd77);
      drain();
   endtask

   task automatic test_random_traffic;
      for (int phase_no = 0; phase_no < 5; phase_no++) begin
         if (phase_no == 0)
            load_setup(32'd0, 32'd4096, 32'h00010000, 32'd25165824, 32'd2863311, 32'h8000,
               $urandom & 32'hFFFFFF);
         else
            load_setup($urandom_range(300), $urandom_range(3800, 8191), $urandom, $urandom,
               $urandom, $urandom & 32'hFFFF, $urandom);
         for (int n = 0; n < 250; n++) begin
            if (n == 100) no_idle = 1'b1;
            if (n == 160) no_idle = 1'b0;
            send_random_bin();
         end
         drain();
      end
   endtask

   initial begin
      band_lo = 0; band_hi = 4096; omega_step = 0; kx_step = 0;
      slowness = 0; cos_sq = 0; two_depth = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_band_and_cone();
      test_extremes();
      test_empty_band();
      test_random_traffic();
      if (mismatches == 0 && expected_bins.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/fk_pse_pkg.sv
hw/rtl/fk_pse_req_if.sv
hw/rtl/fk_pse_rsp_if.sv
hw/rtl/fk_phase_shift_extrapolator.sv
tb/tb_top.sv
